FILE: sv/skts_pkg.sv
// ----------------------------------------------------------------------------
// skts_pkg
// Shared types and constants for the sorted key table search block.
// ----------------------------------------------------------------------------
package skts_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned KEY_W       = 64;
  localparam int unsigned IDX_W       = 10;

  // Input item action codes (code 3 leaves the table unchanged and yields an OK result)
  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_SORT   = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_e;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_LK_PROBE,
    S_LK_CMP,
    S_SO_LOAD,
    S_SO_RD,
    S_SO_CMP,
    S_SO_END,
    S_DONE
  } state_e;

  // One result item
  typedef struct packed {
    status_e           status;
    logic [IDX_W-1:0]  match_index;
  } res_t;

endpackage

FILE: sv/skts_mem.sv
// ----------------------------------------------------------------------------
// skts_mem
// Key store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module skts_mem #(
  parameter int unsigned Depth = skts_pkg::TABLE_DEPTH,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AddrW-1:0]            waddr_i,
  input  logic [skts_pkg::KEY_W-1:0]  wdata_i,
  input  logic [AddrW-1:0]            raddr_i,
  output logic [skts_pkg::KEY_W-1:0]  rdata_o
);

  logic [skts_pkg::KEY_W-1:0] mem [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: sv/skts_ctrl.sv
// ----------------------------------------------------------------------------
// skts_ctrl
// Sequencer for add, bubble sort and binary search over the key store.
// ----------------------------------------------------------------------------
module skts_ctrl #(
  parameter int unsigned Depth = skts_pkg::TABLE_DEPTH,
  parameter int unsigned AddrW = $clog2(Depth),
  parameter int unsigned CntW  = $clog2(Depth + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // incoming item
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  skts_pkg::action_e           in_action_i,
  input  logic [skts_pkg::KEY_W-1:0]  in_key_i,
  // result item
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output skts_pkg::res_t              res_o,
  // memory
  output logic                        we_o,
  output logic [AddrW-1:0]            waddr_o,
  output logic [skts_pkg::KEY_W-1:0]  wdata_o,
  output logic [AddrW-1:0]            raddr_o,
  input  logic [skts_pkg::KEY_W-1:0]  rdata_i,
  // held entry count
  output logic [CntW-1:0]             count_o
);

  skts_pkg::state_e state_q, state_d;
  logic [CntW-1:0]            count_q, count_d;
  logic [skts_pkg::KEY_W-1:0] key_q, key_d;
  logic [skts_pkg::KEY_W-1:0] cur_q, cur_d;
  logic [CntW-1:0]            lo_q, lo_d, hi_q, hi_d;
  logic [AddrW-1:0]           mid_q, mid_d;
  logic [CntW-1:0]            pos_q, pos_d, len_q, len_d;
  logic                       swp_q, swp_d;
  skts_pkg::res_t             res_q, res_d;
  logic [CntW:0]              mid_sum;
  logic [CntW-1:0]            pos_inc;
  logic [CntW-1:0]            len_dec;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= skts_pkg::S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    cur_q <= cur_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    pos_q <= pos_d;
    len_q <= len_d;
    swp_q <= swp_d;
    res_q <= res_d;
  end

  // Midpoint of the open search interval (lo-1, hi)
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} - {{CntW{1'b0}}, 1'b1};
  assign pos_inc = pos_q + 1'b1;
  assign len_dec = len_q - 1'b1;

  // Next state and memory control
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    key_d   = key_q;
    cur_d   = cur_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    pos_d   = pos_q;
    len_d   = len_q;
    swp_d   = swp_q;
    res_d   = res_q;
    we_o    = 1'b0;
    waddr_o = count_q[AddrW-1:0];
    wdata_o = in_key_i;
    raddr_o = '0;

    unique case (state_q)
      skts_pkg::S_IDLE: begin
        if (in_valid_i) begin
          res_d.status      = skts_pkg::ST_OK;
          res_d.match_index = '0;
          state_d           = skts_pkg::S_DONE;
          key_d             = in_key_i;
          unique case (in_action_i)
            skts_pkg::ACT_ADD: begin
              if (count_q < CntW'(Depth)) begin
                we_o    = 1'b1;
                count_d = count_q + 1'b1;
              end else begin
                res_d.status = skts_pkg::ST_FULL;
              end
            end
            skts_pkg::ACT_SORT: begin
              // tables of fewer than two entries are already sorted
              if (count_q > CntW'(1)) begin
                len_d   = count_q;
                state_d = skts_pkg::S_SO_LOAD;
              end
            end
            skts_pkg::ACT_LOOKUP: begin
              lo_d    = '0;
              hi_d    = count_q;
              state_d = skts_pkg::S_LK_PROBE;
            end
            default: ;
          endcase
        end
      end

      // issue a probe read or finish as not found
      skts_pkg::S_LK_PROBE: begin
        if (lo_q < hi_q) begin
          mid_d   = mid_sum[AddrW:1];
          raddr_o = mid_sum[AddrW:1];
          state_d = skts_pkg::S_LK_CMP;
        end else begin
          res_d.status = skts_pkg::ST_NOTFOUND;
          state_d      = skts_pkg::S_DONE;
        end
      end

      skts_pkg::S_LK_CMP: begin
        if (key_q == rdata_i) begin
          res_d.match_index = skts_pkg::IDX_W'(mid_q);
          state_d           = skts_pkg::S_DONE;
        end else begin
          if (key_q < rdata_i) begin
            hi_d = CntW'(mid_q);
          end else begin
            lo_d = CntW'(mid_q) + 1'b1;
          end
          state_d = skts_pkg::S_LK_PROBE;
        end
      end

      // bubble pass: address 0 is being read, take it as the carried key
      skts_pkg::S_SO_LOAD: begin
        cur_d   = rdata_i;
        pos_d   = CntW'(1);
        swp_d   = 1'b0;
        state_d = skts_pkg::S_SO_RD;
      end

      skts_pkg::S_SO_RD: begin
        raddr_o = pos_q[AddrW-1:0];
        state_d = skts_pkg::S_SO_CMP;
      end

      // keep the larger key moving up, write the smaller one behind it
      skts_pkg::S_SO_CMP: begin
        we_o    = 1'b1;
        waddr_o = AddrW'(pos_q - 1'b1);
        if (cur_q > rdata_i) begin
          wdata_o = rdata_i;
          swp_d   = 1'b1;
        end else begin
          wdata_o = cur_q;
          cur_d   = rdata_i;
        end
        pos_d   = pos_inc;
        state_d = (pos_inc == len_q) ? skts_pkg::S_SO_END : skts_pkg::S_SO_RD;
      end

      // park the largest key at the end of the pass
      skts_pkg::S_SO_END: begin
        we_o    = 1'b1;
        waddr_o = len_dec[AddrW-1:0];
        wdata_o = cur_q;
        len_d   = len_dec;
        if (!swp_q || len_dec < CntW'(2)) begin
          state_d = skts_pkg::S_DONE;
        end else begin
          raddr_o = '0;
          state_d = skts_pkg::S_SO_LOAD;
        end
      end

      skts_pkg::S_DONE: begin
        if (res_ready_i) begin
          state_d = skts_pkg::S_IDLE;
        end
      end

      default: state_d = skts_pkg::S_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == skts_pkg::S_IDLE);
  assign res_valid_o = (state_q == skts_pkg::S_DONE);
  assign res_o       = res_q;
  assign count_o     = count_q;

endmodule

FILE: sv/sorted_key_table_search.sv
// ----------------------------------------------------------------------------
// sorted_key_table_search
// Table of 64-bit keys with append, in-place sort and binary search.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_axis: action (add, sort, lookup) and a key.
//   Each item yields one result item on m_axis: status and match index.
//   Add: appends the key at the count. A full table flags full.
//   Lookup: binary search, one read of the key store per probe,
//   up to floor(log2(count))+1 probes; the result then goes to the output
//   register, with a not-found status when the key is absent.
//   Sort: bubble passes over the single-port-read key store, one read
//   and one write per compared pair; ends early on a pass without a swap.
//   One item is in work at a time; s_axis_tready is high only while the
//   sequencer is idle. The result sits in an output register, so the
//   sequencer takes the next item while an earlier result still waits;
//   a stalled receiver holds back at most one further result.
//   Reset empties the table (count to zero); no clearing pass is needed,
//   since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module sorted_key_table_search #(
  parameter int unsigned TableDepth = skts_pkg::TABLE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // [1:0] action, [65:2] key, zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [1:0] status, [11:2] match_index, pad
);

  localparam int unsigned AddrW = $clog2(TableDepth);
  localparam int unsigned CntW  = $clog2(TableDepth + 1);

  logic                       res_valid, res_ready;
  skts_pkg::res_t             res;
  logic                       we;
  logic [AddrW-1:0]           waddr, raddr;
  logic [skts_pkg::KEY_W-1:0] wdata, rdata;
  logic [CntW-1:0]            count;
  logic                       out_valid_q;
  skts_pkg::res_t             out_q;

  skts_ctrl #(
    .Depth (TableDepth),
    .AddrW (AddrW),
    .CntW  (CntW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_action_i (skts_pkg::action_e'(s_axis_tdata[1:0])),
    .in_key_i    (s_axis_tdata[65:2]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .raddr_o     (raddr),
    .rdata_i     (rdata),
    .count_o     (count)
  );

  skts_mem #(
    .Depth (TableDepth),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Output register
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_q.match_index, out_q.status};

  // Checks
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item accepted while previous item in work");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CntW'(TableDepth))
    else $error("entry count beyond table depth");

  a_count_on_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count != $past(count) |-> $past(s_axis_tvalid && s_axis_tready
      && s_axis_tdata[1:0] == skts_pkg::ACT_ADD))
    else $error("entry count changed without an add");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_ready && res.status == skts_pkg::ST_FULL
      |-> count == CntW'(TableDepth))
    else $error("full reported with room left");

endmodule
